[rtl/rle_pkg.sv]
// ---------------------------------------------------------------------------
// rle_pkg
// Shared types and constants for the run-length element decoder.
// ---------------------------------------------------------------------------
`default_nettype none

package rle_pkg;

    localparam int unsigned ELEM_W   = 32;
    localparam int unsigned COUNT_W  = 8;
    localparam int unsigned WIDTH_W  = 3;

    localparam logic [7:0]         CTRL_REPEAT_BIT = 8'h80;
    localparam logic [6:0]         REPEAT_MASK     = 7'h7F;
    localparam logic [COUNT_W-1:0] REPEAT_BIAS     = 8'd3;
    localparam logic [WIDTH_W-1:0] WIDTH_MIN       = 3'd1;
    localparam logic [WIDTH_W-1:0] WIDTH_MAX       = 3'd4;
    localparam logic [WIDTH_W-1:0] WIDTH_RESET     = 3'd4;

    typedef enum logic [1:0] {
        MODE_CONTROL = 2'd0,
        MODE_LITERAL = 2'd1,
        MODE_REPEAT  = 2'd2
    } run_mode_t;

    typedef struct packed {
        run_mode_t          mode;
        logic [COUNT_W-1:0] elements_left;
        logic [1:0]         byte_pos;
        logic [ELEM_W-1:0]  acc;
        logic [COUNT_W-1:0] run_repeat;
    } dec_state_t;

    typedef struct packed {
        logic [ELEM_W-1:0]  element_value;
        logic [COUNT_W-1:0] repeat_count;
        logic               final_res;
        logic               truncated;
    } dec_result_t;

    localparam dec_state_t STATE_CLEAR = '{
        mode:          MODE_CONTROL,
        elements_left: '0,
        byte_pos:      '0,
        acc:           '0,
        run_repeat:    '0
    };

    // Register value 0 acts as 1, values above 4 act as 4.
    function automatic logic [WIDTH_W-1:0] eff_width(input logic [WIDTH_W-1:0] raw);
        logic [WIDTH_W-1:0] w;
        begin
            if (raw == '0)
            begin
                w = WIDTH_MIN;
            end
            else if (raw > WIDTH_MAX)
            begin
                w = WIDTH_MAX;
            end
            else
            begin
                w = raw;
            end
            return w;
        end
    endfunction

endpackage

`default_nettype wire

[rtl/rle_if.sv]
// ---------------------------------------------------------------------------
// rle_if
// Valid/ready channels: compressed byte input and decoded element output.
// ---------------------------------------------------------------------------
`default_nettype none

interface rle_code_if;
    logic       valid;
    logic       ready;
    logic [7:0] code_byte;
    logic       stream_end;

    modport source (output valid, output code_byte, output stream_end, input ready);
    modport sink   (input valid, input code_byte, input stream_end, output ready);
endinterface

interface rle_elem_if;
    logic        valid;
    logic        ready;
    logic [31:0] element_value;
    logic [7:0]  repeat_count;
    logic        final_res;
    logic        truncated;

    modport source (output valid, output element_value, output repeat_count,
                    output final_res, output truncated, input ready);
    modport sink   (input valid, input element_value, input repeat_count,
                    input final_res, input truncated, output ready);
endinterface

`default_nettype wire

[rtl/rle_step.sv]
// ---------------------------------------------------------------------------
// rle_step
// One-byte decode step: next run state and the optional result.
// ---------------------------------------------------------------------------
`default_nettype none

module rle_step (
    input  wire rle_pkg::dec_state_t           state,
    input  wire logic [7:0]                    code_byte,
    input  wire logic                          stream_end,
    input  wire logic [rle_pkg::WIDTH_W-1:0]   width,
    output rle_pkg::dec_state_t                state_next,
    output rle_pkg::dec_result_t               result,
    output logic                               result_valid
);

    logic                          is_data;
    logic [rle_pkg::ELEM_W-1:0]    acc_merged;
    logic [rle_pkg::WIDTH_W-1:0]   pos_inc;
    logic                          elem_done;
    logic [rle_pkg::COUNT_W-1:0]   left_dec;
    logic                          run_over;

    assign is_data    = (state.mode == rle_pkg::MODE_LITERAL) ||
                        (state.mode == rle_pkg::MODE_REPEAT);
    assign acc_merged = state.acc |
                        ({24'd0, code_byte} << {state.byte_pos, 3'b000});
    assign pos_inc    = {1'b0, state.byte_pos} + 3'd1;
    assign elem_done  = (pos_inc >= width);
    assign left_dec   = state.elements_left - 8'd1;
    assign run_over   = (left_dec == '0);

    // next state
    always_comb
    begin
        state_next = state;
        if (!is_data)
        begin
            if ((code_byte & rle_pkg::CTRL_REPEAT_BIT) == 8'd0)
            begin
                state_next.mode          = rle_pkg::MODE_LITERAL;
                state_next.elements_left = code_byte + 8'd1;
                state_next.run_repeat    = 8'd1;
            end
            else
            begin
                state_next.mode          = rle_pkg::MODE_REPEAT;
                state_next.elements_left = 8'd1;
                state_next.run_repeat    = {1'b0, code_byte[6:0] & rle_pkg::REPEAT_MASK}
                                           + rle_pkg::REPEAT_BIAS;
            end
            state_next.byte_pos = '0;
            state_next.acc      = '0;
        end
        else if (elem_done)
        begin
            state_next.elements_left = left_dec;
            state_next.byte_pos      = '0;
            state_next.acc           = '0;
            if (run_over)
            begin
                state_next.mode       = rle_pkg::MODE_CONTROL;
                state_next.run_repeat = '0;
            end
        end
        else
        begin
            state_next.byte_pos = pos_inc[1:0];
            state_next.acc      = acc_merged;
        end
        // any end of stream restarts decoding from a control byte
        if (stream_end)
        begin
            state_next = rle_pkg::STATE_CLEAR;
        end
    end

    // result
    always_comb
    begin
        result       = '0;
        result_valid = 1'b0;
        if (is_data && elem_done)
        begin
            result_valid         = 1'b1;
            result.element_value = acc_merged;
            result.repeat_count  = state.run_repeat;
            result.final_res     = stream_end;
            result.truncated     = stream_end && !run_over;
        end
        else if (stream_end)
        begin
            // ended on a control byte or inside an element
            result_valid     = 1'b1;
            result.final_res = 1'b1;
            result.truncated = 1'b1;
        end
    end

endmodule

`default_nettype wire

[rtl/rle_element_decoder.sv]
// ---------------------------------------------------------------------------
// rle_element_decoder
// Run-length decoder, 1..4 byte pixel elements, a byte a cycle unless stalled.
// ---------------------------------------------------------------------------
//
//  channel    dir  handshake     payload
//  ---------  ---  ------------  ----------------------------------------------
//  code_ch    in   valid/ready   code_byte[7:0], stream_end
//  elem_ch    out  valid/ready   element_value[31:0], repeat_count[7:0],
//                                final_res, truncated
//  cfg        in   cfg_we        cfg_wdata[2:0] -> element_bytes
//
//  One byte per cycle sustained while the result register is free or draining.
//  A byte is staged in the input register, then the decode step updates the
//  run state and loads the result register, which presents it on elem_ch.
//  The decode step's state update is the only loop.
//  rst_n (async, active low) clears run state, valid flags and sets
//  element_bytes to 4. A stall on elem_ch holds the input register only when
//  the result register is full; until then bytes that give no result drain.
//
`default_nettype none

module rle_element_decoder (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_wdata,
    rle_code_if.sink         code_ch,
    rle_elem_if.source       elem_ch
);

    // configuration
    logic [rle_pkg::WIDTH_W-1:0] width_reg;

    // input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_end_reg;

    // run state
    rle_pkg::dec_state_t  state_reg;
    rle_pkg::dec_state_t  state_next;

    // result register
    logic                  out_valid_reg;
    rle_pkg::dec_result_t  out_reg;

    rle_pkg::dec_result_t  step_result;
    logic                  step_valid;
    logic                  advance;
    logic                  in_xfer;

    // The staged byte moves on when the result register is free or draining.
    assign advance         = in_valid_reg && (!out_valid_reg || elem_ch.ready);
    assign code_ch.ready   = !in_valid_reg || advance;
    assign in_xfer         = code_ch.valid && code_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= rle_pkg::WIDTH_RESET;
        end
        else if (cfg_we)
        begin
            width_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (code_ch.ready)
        begin
            in_valid_reg <= code_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            in_byte_reg <= code_ch.code_byte;
            in_end_reg  <= code_ch.stream_end;
        end
    end

    rle_step u_step (
        .state        (state_reg),
        .code_byte    (in_byte_reg),
        .stream_end   (in_end_reg),
        .width        (rle_pkg::eff_width(width_reg)),
        .state_next   (state_next),
        .result       (step_result),
        .result_valid (step_valid)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rle_pkg::STATE_CLEAR;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // Result register: loaded on a step with a result, cleared on transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= step_valid;
        end
        else if (elem_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && step_valid)
        begin
            out_reg <= step_result;
        end
    end

    assign elem_ch.valid         = out_valid_reg;
    assign elem_ch.element_value = out_reg.element_value;
    assign elem_ch.repeat_count  = out_reg.repeat_count;
    assign elem_ch.final_res     = out_reg.final_res;
    assign elem_ch.truncated     = out_reg.truncated;

`ifndef ASSERT_OFF
    // Waiting for a control byte means nothing is half assembled.
    a_ctrl_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.mode == rle_pkg::MODE_CONTROL) |->
            (state_reg.byte_pos == '0 && state_reg.acc == '0))
        else $error("partial element left in control mode");

    // A repeat run holds exactly one element with a count of 3 or more.
    a_repeat_run: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.mode == rle_pkg::MODE_REPEAT) |->
            (state_reg.elements_left == 8'd1 && state_reg.run_repeat >= 8'd3))
        else $error("repeat run state corrupt");

    // A literal run always has elements left and a count of one.
    a_literal_run: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.mode == rle_pkg::MODE_LITERAL) |->
            (state_reg.elements_left != '0 && state_reg.run_repeat == 8'd1))
        else $error("literal run state corrupt");

    // Truncation is only reported on the final result.
    a_trunc_final: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.truncated) |-> out_reg.final_res)
        else $error("truncated without final_res");
`endif

endmodule

`default_nettype wire

[tb/rle_element_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rle_element_checker
// Watches both channels of the element decoder, predicts every decoded
// element from the accepted code bytes and compares it field by field.
// ---------------------------------------------------------------------------

module rle_element_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [2:0] cfg_wdata,
    rle_code_if        code_ch,
    rle_elem_if        elem_ch,
    output int         failures,
    output int         outstanding
);

    // predicted decoder state
    logic [rle_pkg::WIDTH_W-1:0] elem_width;
    rle_pkg::run_mode_t          pred_mode;
    logic [rle_pkg::COUNT_W-1:0] pred_left;
    logic [2:0]                  pred_pos;
    logic [rle_pkg::ELEM_W-1:0]  pred_acc;
    logic [rle_pkg::COUNT_W-1:0] pred_repeat;

    rle_pkg::dec_result_t expected_elems[$];
    int                   mismatches;

    task automatic clear_run_state();
        pred_mode   = rle_pkg::MODE_CONTROL;
        pred_left   = '0;
        pred_pos    = '0;
        pred_acc    = '0;
        pred_repeat = '0;
    endtask

    // result of a stream that ended on a control byte or before an element was complete
    task automatic push_cut_short();
        rle_pkg::dec_result_t r;
        r.element_value = '0;
        r.repeat_count  = '0;
        r.final_res     = 1'b1;
        r.truncated     = 1'b1;
        expected_elems.push_back(r);
        clear_run_state();
    endtask

    task automatic decode_code_byte(input logic [7:0] b, input logic fin);
        rle_pkg::dec_result_t        r;
        logic [rle_pkg::WIDTH_W-1:0] w;
        w = (elem_width == '0) ? rle_pkg::WIDTH_MIN :
            (elem_width > rle_pkg::WIDTH_MAX) ? rle_pkg::WIDTH_MAX : elem_width;
        if (pred_mode != rle_pkg::MODE_LITERAL && pred_mode != rle_pkg::MODE_REPEAT)
        begin
            if ((b & rle_pkg::CTRL_REPEAT_BIT) == '0)
            begin
                pred_mode   = rle_pkg::MODE_LITERAL;
                pred_left   = b + 8'd1;
                pred_repeat = 8'd1;
            end
            else
            begin
                pred_mode   = rle_pkg::MODE_REPEAT;
                pred_left   = 8'd1;
                pred_repeat = {1'b0, b[6:0] & rle_pkg::REPEAT_MASK} + rle_pkg::REPEAT_BIAS;
            end
            pred_pos = '0;
            pred_acc = '0;
            if (fin)
                push_cut_short();
        end
        else
        begin
            pred_acc = pred_acc | ({24'd0, b} << {pred_pos[1:0], 3'b000});
            pred_pos = pred_pos + 3'd1;
            if (pred_pos >= w)
            begin
                r.element_value = pred_acc;
                r.repeat_count  = pred_repeat;
                pred_left = pred_left - 8'd1;
                pred_pos  = '0;
                pred_acc  = '0;
                if (pred_left == '0)
                begin
                    pred_mode   = rle_pkg::MODE_CONTROL;
                    pred_repeat = '0;
                end
                r.final_res = fin;
                r.truncated = fin && (pred_mode != rle_pkg::MODE_CONTROL);
                expected_elems.push_back(r);
                if (fin)
                    clear_run_state();
            end
            else if (fin)
            begin
                push_cut_short();
            end
        end
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            mismatches++;
            $error("%s: expected %0h, actual %0h", name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rle_pkg::dec_result_t want;
        if (!rst_n)
        begin
            elem_width = rle_pkg::WIDTH_RESET;
            clear_run_state();
            expected_elems.delete();
            mismatches = 0;
            failures    <= 0;
            outstanding <= 0;
        end
        else
        begin
            // results leave before new bytes enter: any result out now is older
            if (elem_ch.valid && elem_ch.ready)
            begin
                if (expected_elems.size() == 0)
                begin
                    mismatches++;
                    $error("unexpected transfer: element_value %0h, repeat_count %0h",
                           elem_ch.element_value, elem_ch.repeat_count);
                end
                else
                begin
                    want = expected_elems.pop_front();
                    compare_field("element_value", want.element_value,
                                  elem_ch.element_value);
                    compare_field("repeat_count", 32'(want.repeat_count),
                                  32'(elem_ch.repeat_count));
                    compare_field("final_res", 32'(want.final_res),
                                  32'(elem_ch.final_res));
                    compare_field("truncated", 32'(want.truncated),
                                  32'(elem_ch.truncated));
                end
            end
            if (cfg_we)
                elem_width = cfg_wdata;
            if (code_ch.valid && code_ch.ready)
                decode_code_byte(code_ch.code_byte, code_ch.stream_end);
            failures    <= mismatches;
            outstanding <= expected_elems.size();
        end
    end

endmodule

[tb/rle_element_decoder_test.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rle_element_decoder_test
// Drives compressed byte streams into the element decoder: a directed set of
// corner cases, then random well-formed, cut-short and noise streams under
// every element width, with random gaps and stalls on both channels.
// ---------------------------------------------------------------------------

module rle_element_decoder_test;

    localparam int ITEM_TARGET = 1200;   // about 1200 bytes in all, directed part included
    localparam int GAP_MAX     = 18;
    localparam int HOLD_CYCLES = 400;    // long receiver hold-off for back-pressure
    localparam int SETTLE      = 6;      // lets a staged byte leave the input register
    localparam int STALL_LIMIT = 4000;   // cycles with no transfer before giving up

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we;
    logic [2:0] cfg_wdata;

    rle_code_if code_ch();
    rle_elem_if elem_ch();

    int failures;
    int outstanding;

    // stimulus control
    bit                          steady = 1'b0;   // both sides run without idling
    int                          hold_requests = 0;
    int                          holds_served = 0;
    int                          items_sent = 0;
    int                          idle_cycles = 0;
    logic [rle_pkg::WIDTH_W-1:0] width_reg = rle_pkg::WIDTH_RESET;
    logic [7:0]                  stream_bytes[$];

    always #2 clk = ~clk;

    rle_element_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .code_ch   (code_ch),
        .elem_ch   (elem_ch)
    );

    rle_element_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .code_ch     (code_ch),
        .elem_ch     (elem_ch),
        .failures    (failures),
        .outstanding (outstanding)
    );

    // -----------------------------------------------------------------------
    // Byte sender. valid stays high across back-to-back transfers; it is lowered
    // only for a gap or in drain(), so each step sees one assignment to it.
    // -----------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic fin);
        int gap;
        gap = steady ? 0 : $urandom_range(0, GAP_MAX);
        if (gap > 0)
        begin
            code_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        code_ch.valid      <= 1'b1;
        code_ch.code_byte  <= b;
        code_ch.stream_end <= fin;
        do @(posedge clk); while (!code_ch.ready);
        items_sent++;
    endtask

    // Wait until every predicted element has come out, then give bytes that
    // produce nothing time to leave the pipeline before the block counts as idle.
    task automatic drain();
        code_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Register writes happen only with the decoder idle.
    task automatic write_cfg(input logic [2:0] value);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        width_reg = value;
    endtask

    // Builds a well-formed stream of a few runs at the element width in force.
    // Literal runs are mostly short, now and then up to the full 128 elements.
    task automatic make_stream(input int runs);
        int w;
        int ctrl;
        int data_len;
        w = (width_reg == '0) ? 1 :
            (width_reg > rle_pkg::WIDTH_MAX) ? int'(rle_pkg::WIDTH_MAX) : int'(width_reg);
        stream_bytes.delete();
        repeat (runs)
        begin
            if ($urandom_range(0, 1) == 0)
            begin
                ctrl = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127)
                                                   : $urandom_range(0, 5);
                data_len = (ctrl + 1) * w;
            end
            else
            begin
                ctrl = $urandom_range(128, 255);
                data_len = w;
            end
            stream_bytes.push_back(8'(ctrl));
            repeat (data_len) stream_bytes.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    // Sends the first count bytes; with_end marks the last of them as the end.
    task automatic send_stream(input int count, input bit with_end);
        for (int i = 0; i < count; i++)
            send_byte(stream_bytes[i], with_end && (i == count - 1));
    endtask

    // -----------------------------------------------------------------------
    // Element receiver: random stall before each transfer, none in steady
    // stretches, and a long hold-off whenever the stimulus asks for one.
    // -----------------------------------------------------------------------
    initial
    begin
        int stall;
        elem_ch.ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (holds_served != hold_requests)
            begin
                holds_served++;
                stall = HOLD_CYCLES;
            end
            else if (steady)
            begin
                stall = 0;
            end
            else
            begin
                stall = $urandom_range(0, GAP_MAX);
            end
            if (stall > 0)
            begin
                elem_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            elem_ch.ready <= 1'b1;
            do @(posedge clk); while (!elem_ch.valid);
        end
    end

    // Watchdog: too long without any transfer means the block hung.
    always @(posedge clk)
    begin
        if (!rst_n || (code_ch.valid && code_ch.ready) || (elem_ch.valid && elem_ch.ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // -----------------------------------------------------------------------
    // Stimulus
    // -----------------------------------------------------------------------
    initial
    begin
        int kind;
        cfg_we             <= 1'b0;
        cfg_wdata          <= rle_pkg::WIDTH_RESET;
        code_ch.valid      <= 1'b0;
        code_ch.code_byte  <= 8'h00;
        code_ch.stream_end <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset width 4: one literal element, little-endian assembly, clean end
        send_byte(8'h00, 1'b0);
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b0);
        send_byte(8'h56, 1'b0);
        send_byte(8'h78, 1'b1);

        // width 1: shortest repeat run, two literals, then end on a control byte
        write_cfg(3'd1);
        send_byte(8'h80, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'h80, 1'b1);

        // end inside a run: element comes out complete but flagged truncated
        send_byte(8'h02, 1'b0);
        send_byte(8'h11, 1'b0);
        send_byte(8'h22, 1'b1);

        // width 2: end inside an element
        write_cfg(3'd2);
        send_byte(8'h00, 1'b0);
        send_byte(8'hAB, 1'b1);

        // longest repeat (130), then the longest literal cut after one element
        send_byte(8'hFF, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'hCD, 1'b0);
        send_byte(8'hEF, 1'b1);

        // width drops from 2 to 1 with one byte gathered: next byte completes it
        send_byte(8'h00, 1'b0);
        send_byte(8'h11, 1'b0);
        write_cfg(3'd1);
        send_byte(8'h22, 1'b1);

        // back-pressure: receiver holds off while a full literal run streams in
        // at one byte per element, so the result side fills and the input stalls
        write_cfg(3'd1);
        hold_requests++;
        steady = 1'b1;
        send_byte(8'h7F, 1'b0);
        for (int i = 0; i < 128; i++)
            send_byte(8'($urandom_range(0, 255)), i == 127);
        steady = 1'b0;
        // sender pauses here until every element has come out
        drain();

        // random phases, each under a fresh width setting (0 and 5..7 included)
        while (items_sent < ITEM_TARGET)
        begin
            write_cfg(3'($urandom_range(0, 7)));
            steady = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 14) == 0)
                hold_requests++;
            repeat ($urandom_range(1, 4))
            begin
                kind = $urandom_range(0, 9);
                make_stream($urandom_range(1, 4));
                if (kind < 7)
                begin
                    send_stream(stream_bytes.size(), 1'b1);
                end
                else if (kind < 9)
                begin
                    // cut short: may end on a control byte, mid-element or mid-run
                    send_stream($urandom_range(1, stream_bytes.size()), 1'b1);
                end
                else
                begin
                    repeat ($urandom_range(3, 20))
                        send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
                end
            end
            // sometimes leave a stream open so the next width lands mid-element
            if ($urandom_range(0, 5) == 0)
            begin
                make_stream(1);
                send_stream($urandom_range(1, stream_bytes.size()), 1'b0);
            end
            steady = 1'b0;
        end

        drain();
        if (failures == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
